// ----- design/phx_pkg.sv -----
// Shared types and constants for the Philox4x64 counter-based generator.
package phx_pkg;

  typedef logic [63:0] word_t;

  // A 256-bit Philox block; element 0 is counter word zero.
  typedef word_t [3:0] block_t;

  localparam int unsigned ROUND_COUNT_DEF = 10;
  localparam int unsigned CFG_INDEX_W     = 3;

  localparam word_t MUL_A  = 64'hD2E7_470E_E14C_6C93;
  localparam word_t MUL_B  = 64'hCA5A_8263_9512_1157;
  localparam word_t WEYL_A = 64'h9E37_79B9_7F4A_7C15;
  localparam word_t WEYL_B = 64'hBB67_AE85_84CA_A73B;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MASTER_SEED   = 3'd0,
    REG_STREAM_NUMBER = 3'd1,
    REG_SCENARIO      = 3'd2,
    REG_RUN           = 3'd3,
    REG_OBJECT        = 3'd4
  } cfg_reg_t;

  // Control that travels alongside each block through the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] sel;
  } ctl_t;

  // Partial products of both 64x64 multiplies plus the pre-keyed pass-through words.
  typedef struct packed {
    word_t a_ll;
    word_t a_lh;
    word_t a_hl;
    word_t a_hh;
    word_t b_ll;
    word_t b_lh;
    word_t b_hl;
    word_t b_hh;
    word_t x0;
    word_t x2;
  } part_t;

endpackage

// ----- design/philox4x64_counter_rng.sv -----
// Top level of the pipelined Philox4x64 counter-based random generator.
//
//  Channel   Signals                                   Direction  Handshake
//  request   start, busy, draw_position                in         start & !busy
//  result    result_valid, random_word                 out        strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid & cfg_ready
//
// One request is taken every cycle while busy is low. A request register, two
// register stages per round (partial products, then product assembly) and an
// output register lie between the request and the result strobe.
// Reset clears the valid bits and the configuration registers; busy is high
// only during reset. Nothing in the pipeline ever stalls.
module philox4x64_counter_rng
  import phx_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [63:0]            draw_position,
  output logic                   result_valid,
  output logic [63:0]            random_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  localparam int unsigned LATENCY = 2 * ROUND_COUNT + 2;

  word_t  seed_word;
  word_t  stream_number;
  word_t  scenario_number;
  word_t  run_number;
  word_t  object_number;

  ctl_t   in_ctl;
  word_t  in_ctr3;

  ctl_t   ctl [0:ROUND_COUNT];
  block_t blk [0:ROUND_COUNT];

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_word       <= '0;
      stream_number   <= '0;
      scenario_number <= '0;
      run_number      <= '0;
      object_number   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MASTER_SEED:   seed_word       <= cfg_data;
        REG_STREAM_NUMBER: stream_number   <= cfg_data;
        REG_SCENARIO:      scenario_number <= cfg_data;
        REG_RUN:           run_number      <= cfg_data;
        REG_OBJECT:        object_number   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request register: the low two bits pick the output word, the rest is the counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_ctl.valid <= 1'b0;
    end else begin
      in_ctl.valid <= start && !busy;
    end
    in_ctl.sel <= draw_position[1:0];
    in_ctr3    <= {2'b00, draw_position[63:2]};
  end

  assign ctl[0]    = in_ctl;
  assign blk[0][0] = scenario_number;
  assign blk[0][1] = run_number;
  assign blk[0][2] = object_number;
  assign blk[0][3] = in_ctr3;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    // The key schedule is a fixed offset per round, so it is added here once.
    localparam word_t KOFF0 = WEYL_A * 64'(r);
    localparam word_t KOFF1 = WEYL_B * 64'(r);

    word_t key0;
    word_t key1;

    assign key0 = seed_word + KOFF0;
    assign key1 = stream_number + KOFF1;

    phx_round u_round (
      .clk     (clk),
      .rst     (rst),
      .in_ctl  (ctl[r]),
      .in_blk  (blk[r]),
      .key0    (key0),
      .key1    (key1),
      .out_ctl (ctl[r+1]),
      .out_blk (blk[r+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl[ROUND_COUNT].valid;
    end
  end

  always_ff @(posedge clk) begin
    random_word <= blk[ROUND_COUNT][ctl[ROUND_COUNT].sel];
  end

  a_request_gives_result: assert property (
    @(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY result_valid
  ) else $error("request did not produce a result at the expected latency");

  a_result_has_request: assert property (
    @(posedge clk) disable iff (rst)
    result_valid |-> $past(start, LATENCY)
  ) else $error("result strobe without a matching request");

  a_seed_write: assert property (
    @(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_MASTER_SEED) |=>
      (seed_word == $past(cfg_data))
  ) else $error("seed write was not taken");

  a_object_write: assert property (
    @(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_OBJECT) |=>
      (object_number == $past(cfg_data))
  ) else $error("object number write was not taken");

endmodule

// ----- design/phx_mul_stage.sv -----
// First half of a Philox round: 32x32 partial products and key mixing.
module phx_mul_stage
  import phx_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ctl_t   in_ctl,
  input  block_t in_blk,
  input  word_t  key0,
  input  word_t  key1,
  output ctl_t   out_ctl,
  output part_t  out_part
);

  localparam logic [31:0] MA_LO = MUL_A[31:0];
  localparam logic [31:0] MA_HI = MUL_A[63:32];
  localparam logic [31:0] MB_LO = MUL_B[31:0];
  localparam logic [31:0] MB_HI = MUL_B[63:32];

  part_t part_next;

  always_comb begin
    part_next.a_ll = 64'(MA_LO) * 64'(in_blk[0][31:0]);
    part_next.a_lh = 64'(MA_LO) * 64'(in_blk[0][63:32]);
    part_next.a_hl = 64'(MA_HI) * 64'(in_blk[0][31:0]);
    part_next.a_hh = 64'(MA_HI) * 64'(in_blk[0][63:32]);
    part_next.b_ll = 64'(MB_LO) * 64'(in_blk[2][31:0]);
    part_next.b_lh = 64'(MB_LO) * 64'(in_blk[2][63:32]);
    part_next.b_hl = 64'(MB_HI) * 64'(in_blk[2][31:0]);
    part_next.b_hh = 64'(MB_HI) * 64'(in_blk[2][63:32]);
    part_next.x0   = in_blk[1] ^ key0;
    part_next.x2   = in_blk[3] ^ key1;
  end

  // Only the valid bit is reset; the select and data simply follow it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
    out_ctl.sel <= in_ctl.sel;
    out_part    <= part_next;
  end

endmodule

// ----- design/phx_mix_stage.sv -----
// Second half of a Philox round: assemble 128-bit products and permute the words.
module phx_mix_stage
  import phx_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ctl_t   in_ctl,
  input  part_t  in_part,
  output ctl_t   out_ctl,
  output block_t out_blk
);

  logic [127:0] prod_a;
  logic [127:0] prod_b;
  block_t       blk_next;

  always_comb begin
    prod_a = {in_part.a_hh, in_part.a_ll}
           + {32'b0, in_part.a_lh, 32'b0}
           + {32'b0, in_part.a_hl, 32'b0};
    prod_b = {in_part.b_hh, in_part.b_ll}
           + {32'b0, in_part.b_lh, 32'b0}
           + {32'b0, in_part.b_hl, 32'b0};
    blk_next[0] = prod_b[127:64] ^ in_part.x0;
    blk_next[1] = prod_b[63:0];
    blk_next[2] = prod_a[127:64] ^ in_part.x2;
    blk_next[3] = prod_a[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
    out_ctl.sel <= in_ctl.sel;
    out_blk     <= blk_next;
  end

endmodule

// ----- design/phx_round.sv -----
// One Philox round as two pipeline stages: multiply, then combine.
module phx_round
  import phx_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ctl_t   in_ctl,
  input  block_t in_blk,
  input  word_t  key0,
  input  word_t  key1,
  output ctl_t   out_ctl,
  output block_t out_blk
);

  ctl_t  mid_ctl;
  part_t mid_part;

  phx_mul_stage u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (in_ctl),
    .in_blk   (in_blk),
    .key0     (key0),
    .key1     (key1),
    .out_ctl  (mid_ctl),
    .out_part (mid_part)
  );

  phx_mix_stage u_mix (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (mid_ctl),
    .in_part (mid_part),
    .out_ctl (out_ctl),
    .out_blk (out_blk)
  );

endmodule
